/* rtl/lkvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Item formats of both channels, the cell command and status structs and the
// sizes of the cell row.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] read_value;
      logic                    evicted;
   } rsp_item_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic              clear;
      logic              lookup;
      logic              update;
      logic              is_set;
      logic              hit;
      logic              evict;
      logic [RANK_W-1:0] hit_rank;
      logic [RANK_W-1:0] victim_rank;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } cell_cmd_type;

   // A cell drives its rank and value only when its key matched.
   typedef struct packed {
      logic              match;
      logic [RANK_W-1:0] hit_rank;
      logic [VAL_W-1:0]  hit_value;
   } cell_status_type;

endpackage
`default_nettype wire

/* rtl/lkvc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the cache
// Holds a key, a value, a valid bit and a recency rank. Compares its key in
// the lookup phase and applies promotion, aging or insertion in the update
// phase. A free-cell token runs along the row so the lowest free cell wins.
// ----------------------------------------------------------------------------
module lkvc_cell
   import lkvc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cell_cmd_type    cmd,
   input  wire logic            free_before_in,
   output logic                 free_before_out,
   output cell_status_type      status
);

   logic              valid_ff, valid_in;
   logic              match_ff, match_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic              is_target;
   logic              is_victim;
   logic              take;

   assign free_before_out = free_before_in | ~valid_ff;
   assign is_target       = ~valid_ff & ~free_before_in;
   assign is_victim       = valid_ff & (rank_ff == cmd.victim_rank);
   assign take            = cmd.evict ? is_victim : is_target;

   always_comb begin
      valid_in = valid_ff;
      match_in = match_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
         match_in = 1'b0;
         rank_in  = '0;
      end else if (cmd.lookup) begin
         match_in = valid_ff & (key_ff == cmd.key);
      end else if (cmd.update) begin
         if (cmd.hit) begin
            if (match_ff) begin
               rank_in = '0;
               if (cmd.is_set) begin
                  value_in = cmd.value;
               end
            end else if (valid_ff && (rank_ff < cmd.hit_rank)) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end else if (cmd.is_set) begin
            if (take) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               value_in = cmd.value;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign status.match     = match_ff;
   assign status.hit_rank  = match_ff ? rank_ff : '0;
   assign status.hit_value = match_ff ? value_ff : '0;

endmodule
`default_nettype wire

/* rtl/lru_key_value_cache.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Requests enter on req_valid/req_ready as req_item_type items (get or set
// with key and value). Each request gives one rsp_item_type item on
// rsp_valid/rsp_ready: found, the read value on a get hit, and whether a set
// evicted the least recent entry.
// An item passes through three steps: the accept step, a lookup step in which
// every cell compares the key in parallel, and an update step in which the
// cells promote, age or insert. The result is registered in the update step,
// and a new item is accepted only once the last one has left that step.
// The result sits in an output register, so a new item is taken while it
// waits; a stalled receiver holds back only the update step of the next one.
// csr_capacity writes the capacity (1 to 16; zero reads as one, above 16 as
// 16) and clears the store. Reset empties the store and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_item_type     req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_item_type          rsp_item,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_capacity
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff, rsp_item_in;
   req_item_type       req_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] cap_eff;
   logic               accept;
   logic               clear;
   logic               update_en;
   logic               hit;
   logic               evict;
   logic [RANK_W-1:0]  hit_rank;
   logic [VAL_W-1:0]   hit_value;
   cell_cmd_type       cmd;
   cell_status_type    cell_status [ENTRIES];
   logic [ENTRIES:0]   free_chain;

   assign csr_ready = (state_ff == ST_IDLE);
   assign clear     = csr_valid & csr_ready;
   // A pending configuration write goes first.
   assign req_ready = (state_ff == ST_IDLE) & ~csr_valid;
   assign accept    = req_valid & req_ready;
   assign update_en = (state_ff == ST_UPDATE) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = COUNT_W'(1);
      end else if (int'(cap_ff) > ENTRIES) begin
         cap_eff = COUNT_W'(ENTRIES);
      end else begin
         cap_eff = COUNT_W'(cap_ff);
      end
   end

   always_comb begin
      hit       = 1'b0;
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit       = hit | cell_status[i].match;
         hit_rank  = hit_rank | cell_status[i].hit_rank;
         hit_value = hit_value | cell_status[i].hit_value;
      end
   end

   assign evict = (count_ff >= cap_eff);

   always_comb begin
      cmd.clear       = clear;
      cmd.lookup      = (state_ff == ST_LOOKUP);
      cmd.update      = update_en;
      cmd.is_set      = (req_ff.req_type == REQ_SET);
      cmd.hit         = hit;
      cmd.evict       = evict;
      cmd.hit_rank    = hit_rank;
      // Ranks of valid cells are exactly 0 to count-1, so the oldest is count-1.
      cmd.victim_rank = RANK_W'(count_ff - COUNT_W'(1));
      cmd.key         = req_ff.key;
      cmd.value       = req_ff.value;
   end

   assign free_chain[0] = 1'b0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkvc_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd),
         .free_before_in  (free_chain[g]),
         .free_before_out (free_chain[g+1]),
         .status          (cell_status[g])
      );
   end

   always_comb begin
      rsp_item_in.found      = hit;
      rsp_item_in.read_value = (hit && (req_ff.req_type == REQ_GET)) ? hit_value : '0;
      rsp_item_in.evicted    = ~hit & (req_ff.req_type == REQ_SET) & evict;
   end

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (update_en && !hit && (req_ff.req_type == REQ_SET) && !evict) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (update_en) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
         count_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (clear) begin
            cap_ff <= csr_capacity;
         end
         if (update_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (update_en) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

/* rtl/lkvc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Watches the top level's channels and flags results that cannot occur.
// ----------------------------------------------------------------------------
module lkvc_checker
   import lkvc_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rsp_item_type     rsp_item
);

   // A hit never evicts, and a set that evicts never found its key.
   a_found_evict_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.found && rsp_item.evicted))
      else $error("found and evicted both set");

   a_read_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.found) |-> (rsp_item.read_value == '0))
      else $error("nonzero read value without a hit");

   // The block works on one item at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed or dropped");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_item     (rsp_item)
);
`default_nettype wire
